>>> rtl/core/remote_pairing_filter_core_defines.svh
// ----------------------------------------------------------------------------
// Remote pairing filter assertion macros
// Shared property forms for the checker: same-cycle and next-cycle implication
// under an active-low synchronous reset.
// ----------------------------------------------------------------------------
`ifndef REMOTE_PAIRING_FILTER_CORE_DEFINES_SVH
`define REMOTE_PAIRING_FILTER_CORE_DEFINES_SVH

// ante implies cons at the same edge
`define RPF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons at the next edge
`define RPF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rpf_pkg.sv
// ----------------------------------------------------------------------------
// Remote pairing filter package
// Beat types, opcode and register codes, job classes and the key compare.
// ----------------------------------------------------------------------------
`default_nettype none

package rpf_pkg;

    localparam int KEY_W           = 32;
    localparam int ELAPSED_W       = 20;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int NUM_STATIC_REGS = 4;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX     = 20'hFFFFF;
    localparam logic [ELAPSED_W-1:0] TIMEOUT_DEFAULT = 20'd30000;
    localparam logic [1:0]           REQUIRED_PRIOR  = 2'd2;

    localparam logic [2:0] OP_EVENT  = 3'd0;
    localparam logic [2:0] OP_TICK   = 3'd1;
    localparam logic [2:0] OP_START  = 3'd2;
    localparam logic [2:0] OP_CANCEL = 3'd3;
    localparam logic [2:0] OP_UNPAIR = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATIC_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STATIC_0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STATIC_1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STATIC_2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STATIC_3     = 3'd5;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  remote_type;
        logic [15:0] device_id;
        logic [7:0]  group_id;
        logic        is_on_command;
    } t_item;

    typedef struct packed {
        logic forward_event;
        logic newly_paired;
        logic paired_table_full;
        logic pairing_active;
        logic pairing_started;
        logic pairing_timed_out;
        logic pairing_cancelled;
    } t_res;

    typedef enum logic [2:0] {
        CL_NOP,
        CL_EVENT,
        CL_TICK,
        CL_START,
        CL_CANCEL,
        CL_UNPAIR
    } t_cls;

    typedef struct packed {
        t_cls             cls;
        logic [KEY_W-1:0] key;
        logic             learnable;
    } t_job;

    typedef struct packed {
        logic [ELAPSED_W-1:0]                  timeout;
        logic [2:0]                            static_count;
        logic [NUM_STATIC_REGS-1:0][KEY_W-1:0] remote;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PSCAN,
        ST_CSCAN,
        ST_DONE
    } t_state;

    function automatic logic key_match(input logic [KEY_W-1:0] entry,
                                       input logic [KEY_W-1:0] key);
        logic hit;
        if (key[7:0] == 8'd0) begin
            hit = ({entry[KEY_W-1:8], 8'd0} == key);
        end else begin
            hit = (entry == key);
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/remote_pairing_filter_core.sv
// ----------------------------------------------------------------------------
// Remote pairing filter core
// Filters decoded remote events against static and learned remotes, learns
// new remotes in pairing mode and reports one result beat per input beat.
// ----------------------------------------------------------------------------
// Input beats enter through push/full into a two-deep job queue; result beats
// leave through empty/pop from a one-beat output register, one per input beat,
// in order. The user must write configuration through i_cfg_we/i_cfg_idx/
// i_cfg_data only while no beat is in flight; the core does not enforce it.
// Tick, start, cancel, unpair and unknown opcodes pass from the idle state
// straight to the done state and then into the output register. A remote
// event scans the paired table and then, when it is unknown, pairing mode is
// on and it can be learned, the candidate list, one stored key per cycle
// through a single read port of each store, before it reaches the done
// state. The stores hold up to 16 paired and 20 candidate keys by default.
// Jobs are worked one at a time; the queue takes up to two more meanwhile.
// Reset clears both fill levels, pairing mode and the elapsed tick count and
// empties the output register; configuration returns to its reset values.
// When the receiver stalls, the result beat holds, the back end waits with the
// next result, and full rises once two more beats are queued.
// ----------------------------------------------------------------------------
`default_nettype none

module remote_pairing_filter_core #(
    parameter int PAIRED_DEPTH    = 16,
    parameter int CANDIDATE_LIMIT = 20,
    parameter int STATIC_SLOTS    = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  rpf_pkg::t_item                   i_item,
    output logic                             empty,
    input  logic                             pop,
    output rpf_pkg::t_res                    o_result,
    input  logic                             i_cfg_we,
    input  logic [rpf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rpf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rpf_pkg::*;

    t_cfg r_cfg;
    logic w_job_vld;
    t_job w_job;
    logic w_job_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout      <= TIMEOUT_DEFAULT;
            r_cfg.static_count <= '0;
            r_cfg.remote       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx) inside
                REG_TIMEOUT: begin
                    r_cfg.timeout <= i_cfg_data[ELAPSED_W-1:0];
                end
                REG_STATIC_COUNT: begin
                    r_cfg.static_count <= i_cfg_data[2:0];
                end
                REG_STATIC_0, REG_STATIC_1, REG_STATIC_2, REG_STATIC_3: begin
                    r_cfg.remote[2'(i_cfg_idx - REG_STATIC_0)] <= i_cfg_data[KEY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    rpf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .o_full    (full),
        .o_job_vld (w_job_vld),
        .o_job     (w_job),
        .i_job_pop (w_job_pop)
    );

    rpf_back #(
        .PAIRED_DEPTH    (PAIRED_DEPTH),
        .CANDIDATE_LIMIT (CANDIDATE_LIMIT),
        .STATIC_SLOTS    (STATIC_SLOTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_job_vld (w_job_vld),
        .i_job     (w_job),
        .o_job_pop (w_job_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

>>> rtl/core/rpf_front.sv
// ----------------------------------------------------------------------------
// Remote pairing filter front end
// Accepts input beats, classifies them into jobs and queues up to two of them.
// ----------------------------------------------------------------------------
`default_nettype none

module rpf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rpf_pkg::t_item i_item,
    output logic          o_full,
    output logic          o_job_vld,
    output rpf_pkg::t_job o_job,
    input  logic          i_job_pop
);
    import rpf_pkg::*;

    t_job       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_job       w_job;
    logic       w_wr;
    logic       w_rd;

    always_comb begin
        w_job.key       = {i_item.remote_type, i_item.device_id, i_item.group_id};
        w_job.learnable = i_item.is_on_command && (i_item.group_id != 8'd0);
        unique case (i_item.opcode)
            OP_EVENT:  w_job.cls = CL_EVENT;
            OP_TICK:   w_job.cls = CL_TICK;
            OP_START:  w_job.cls = CL_START;
            OP_CANCEL: w_job.cls = CL_CANCEL;
            OP_UNPAIR: w_job.cls = CL_UNPAIR;
            default:   w_job.cls = CL_NOP;
        endcase
    end

    assign o_full    = (r_cnt == 2'd2);
    assign o_job_vld = (r_cnt != 2'd0);
    assign o_job     = r_q[r_rp];
    assign w_wr      = i_push && !o_full;
    assign w_rd      = i_job_pop && o_job_vld;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rpf_back.sv
// ----------------------------------------------------------------------------
// Remote pairing filter back end
// Runs one job at a time: scans the paired and candidate stores one entry per
// cycle, updates pairing state and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rpf_back #(
    parameter int PAIRED_DEPTH    = 16,
    parameter int CANDIDATE_LIMIT = 20,
    parameter int STATIC_SLOTS    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rpf_pkg::t_cfg i_cfg,
    input  logic          i_job_vld,
    input  rpf_pkg::t_job i_job,
    output logic          o_job_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output rpf_pkg::t_res o_result
);
    import rpf_pkg::*;

    localparam int PAW = (PAIRED_DEPTH > 1) ? $clog2(PAIRED_DEPTH) : 1;
    localparam int PCW = $clog2(PAIRED_DEPTH + 1);
    localparam int CAW = $clog2(CANDIDATE_LIMIT);
    localparam int CCW = $clog2(CANDIDATE_LIMIT + 1);
    localparam logic [PCW-1:0] P_FULL = PCW'(PAIRED_DEPTH);
    localparam logic [CCW-1:0] C_FULL = CCW'(CANDIDATE_LIMIT);

    logic [KEY_W-1:0] r_pmem [PAIRED_DEPTH];
    logic [KEY_W-1:0] r_cmem [CANDIDATE_LIMIT];
    logic [KEY_W-1:0] r_prd;
    logic [KEY_W-1:0] r_crd;

    t_state               r_state,   n_state;
    t_job                 r_job,     n_job;
    logic                 r_hit,     n_hit;
    logic [1:0]           r_seen,    n_seen;
    logic [PCW-1:0]       r_paddr,   n_paddr;
    logic                 r_pvld,    n_pvld;
    logic [CCW-1:0]       r_caddr,   n_caddr;
    logic                 r_cvld,    n_cvld;
    logic [PCW-1:0]       r_pcnt,    n_pcnt;
    logic [CCW-1:0]       r_ccnt,    n_ccnt;
    logic                 r_on,      n_on;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    t_res                 r_res,     n_res;
    logic                 r_out_vld, n_out_vld;
    t_res                 r_out,     n_out;

    logic                 w_pre;
    logic                 w_cre;
    logic                 w_pwe;
    logic                 w_cwe;
    logic [PAW-1:0]       w_pwaddr;
    logic [CAW-1:0]       w_cwaddr;
    logic [CCW-1:0]       w_cbase;
    logic [2:0]           w_nstatic;
    logic                 w_static_hit;
    logic [ELAPSED_W-1:0] w_el_inc;
    logic                 w_p_done;
    logic                 w_c_done;
    logic                 w_load;

    assign w_nstatic = (i_cfg.static_count > 3'(STATIC_SLOTS)) ? 3'(STATIC_SLOTS)
                                                                : i_cfg.static_count;

    always_comb begin
        w_static_hit = 1'b0;
        for (int s = 0; s < NUM_STATIC_REGS; s++) begin
            if ((3'(s) < w_nstatic) && key_match(i_cfg.remote[s], i_job.key)) begin
                w_static_hit = 1'b1;
            end
        end
    end

    assign w_el_inc = (r_elapsed == ELAPSED_MAX) ? r_elapsed : r_elapsed + ELAPSED_W'(1);
    assign w_p_done = (r_paddr >= r_pcnt) && !r_pvld;
    assign w_c_done = (r_caddr >= r_ccnt) && !r_cvld;
    assign w_load   = !r_out_vld || i_pop;
    assign w_cbase  = (r_ccnt >= C_FULL) ? '0 : r_ccnt;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_vld) begin
                    n_state = (i_job.cls == CL_EVENT) ? ST_PSCAN : ST_DONE;
                end
            end
            ST_PSCAN: begin
                if (w_p_done) begin
                    n_state = (!r_hit && r_on && r_job.learnable) ? ST_CSCAN : ST_DONE;
                end
            end
            ST_CSCAN: begin
                if (w_c_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_job     = r_job;
        n_hit     = r_hit;
        n_seen    = r_seen;
        n_paddr   = r_paddr;
        n_pvld    = r_pvld;
        n_caddr   = r_caddr;
        n_cvld    = r_cvld;
        n_pcnt    = r_pcnt;
        n_ccnt    = r_ccnt;
        n_on      = r_on;
        n_elapsed = r_elapsed;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_pop;
        o_job_pop = 1'b0;
        w_pre     = 1'b0;
        w_cre     = 1'b0;
        w_pwe     = 1'b0;
        w_cwe     = 1'b0;
        w_pwaddr  = r_pcnt[PAW-1:0];
        w_cwaddr  = w_cbase[CAW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_vld) begin
                    o_job_pop            = 1'b1;
                    n_job                = i_job;
                    n_res                = '0;
                    n_res.pairing_active = r_on;
                    unique case (i_job.cls)
                        CL_EVENT: begin
                            n_hit   = w_static_hit;
                            n_paddr = '0;
                            n_pvld  = 1'b0;
                        end
                        CL_TICK: begin
                            if (r_on) begin
                                n_elapsed = w_el_inc;
                                if (w_el_inc > i_cfg.timeout) begin
                                    n_on                    = 1'b0;
                                    n_ccnt                  = '0;
                                    n_res.pairing_timed_out = 1'b1;
                                    n_res.pairing_active    = 1'b0;
                                end
                            end
                        end
                        CL_START: begin
                            if (!r_on) begin
                                n_ccnt                = '0;
                                n_on                  = 1'b1;
                                n_res.pairing_started = 1'b1;
                            end
                            n_elapsed            = '0;
                            n_res.pairing_active = 1'b1;
                        end
                        CL_CANCEL: begin
                            if (r_on) begin
                                n_on                    = 1'b0;
                                n_ccnt                  = '0;
                                n_res.pairing_cancelled = 1'b1;
                                n_res.pairing_active    = 1'b0;
                            end
                        end
                        CL_UNPAIR: begin
                            n_pcnt = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PSCAN: begin
                if (r_paddr < r_pcnt) begin
                    w_pre   = 1'b1;
                    n_paddr = r_paddr + PCW'(1);
                    n_pvld  = 1'b1;
                end else begin
                    n_pvld = 1'b0;
                end
                if (r_pvld && key_match(r_prd, r_job.key)) begin
                    n_hit = 1'b1;
                end
                if (w_p_done) begin
                    n_res.forward_event = r_hit;
                    n_caddr             = '0;
                    n_cvld              = 1'b0;
                    n_seen              = '0;
                end
            end
            ST_CSCAN: begin
                if (r_caddr < r_ccnt) begin
                    w_cre   = 1'b1;
                    n_caddr = r_caddr + CCW'(1);
                    n_cvld  = 1'b1;
                end else begin
                    n_cvld = 1'b0;
                end
                if (r_cvld && (r_crd == r_job.key) && (r_seen != REQUIRED_PRIOR)) begin
                    n_seen = r_seen + 2'd1;
                end
                if (w_c_done) begin
                    if (r_seen == REQUIRED_PRIOR) begin
                        if (r_pcnt < P_FULL) begin
                            w_pwe              = 1'b1;
                            n_pcnt             = r_pcnt + PCW'(1);
                            n_res.newly_paired = 1'b1;
                        end else begin
                            n_res.paired_table_full = 1'b1;
                        end
                        n_on                 = 1'b0;
                        n_ccnt               = '0;
                        n_res.pairing_active = 1'b0;
                    end else begin
                        w_cwe  = 1'b1;
                        n_ccnt = w_cbase + CCW'(1);
                    end
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_pwe) begin
            r_pmem[w_pwaddr] <= r_job.key;
        end
        if (w_pre) begin
            r_prd <= r_pmem[r_paddr[PAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cwe) begin
            r_cmem[w_cwaddr] <= r_job.key;
        end
        if (w_cre) begin
            r_crd <= r_cmem[r_caddr[CAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_hit   <= n_hit;
        r_seen  <= n_seen;
        r_paddr <= n_paddr;
        r_caddr <= n_caddr;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pvld    <= 1'b0;
            r_cvld    <= 1'b0;
            r_pcnt    <= '0;
            r_ccnt    <= '0;
            r_on      <= 1'b0;
            r_elapsed <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pvld    <= n_pvld;
            r_cvld    <= n_cvld;
            r_pcnt    <= n_pcnt;
            r_ccnt    <= n_ccnt;
            r_on      <= n_on;
            r_elapsed <= n_elapsed;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_empty  = !r_out_vld;
    assign o_result = r_out;

endmodule

`default_nettype wire

>>> rtl/core/rpf_checker.sv
// ----------------------------------------------------------------------------
// Remote pairing filter checker
// Port-level properties of the core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "remote_pairing_filter_core_defines.svh"

module rpf_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           push,
    input wire logic           full,
    input wire logic           empty,
    input wire logic           pop,
    input wire rpf_pkg::t_res  o_result
);
    import rpf_pkg::*;

    `RPF_ASSERT_NXT(a_result_holds, i_clk, i_rst_n, (!empty && !pop), (!empty && $stable(o_result)), "result beat changed while stalled")
    `RPF_ASSERT_IMP(a_reset_clean, i_clk, i_rst_n, $rose(i_rst_n), (empty && !full), "queues not empty after reset")
    `RPF_ASSERT_IMP(a_one_event, i_clk, i_rst_n, !empty, ($countones({o_result.forward_event, o_result.newly_paired, o_result.paired_table_full, o_result.pairing_started, o_result.pairing_timed_out, o_result.pairing_cancelled}) <= 1), "more than one event flag in a result")
    `RPF_ASSERT_IMP(a_end_inactive, i_clk, i_rst_n, (!empty && (o_result.newly_paired || o_result.paired_table_full || o_result.pairing_timed_out || o_result.pairing_cancelled)), !o_result.pairing_active, "pairing still active after it ended")
    `RPF_ASSERT_IMP(a_start_active, i_clk, i_rst_n, (!empty && o_result.pairing_started), o_result.pairing_active, "pairing inactive after start")

    logic w_unused;
    assign w_unused = push;

endmodule

bind remote_pairing_filter_core rpf_checker u_rpf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Remote pairing filter core testbench
// Drives remote events, ticks and pairing commands through the push/full side
// under several static-remote and timeout settings, predicts result beats with
// an in-bench model of the filter and pairing state (fixed values for part of
// the directed run) and compares each popped beat field by field. Both sides
// idle at random in most settings; a long receiver stall backs the block up.
// ----------------------------------------------------------------------------
module testbench;
    import rpf_pkg::*;

    localparam int PAIRED_SLOTS = 16;
    localparam int CAND_SLOTS   = 20;
    localparam int POOL_SIZE    = 24;
    localparam int PHASE_BEATS  = 300;
    localparam int NUM_PHASES   = 6;
    localparam int MAX_REPORTS  = 40;

    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    t_item                 i_item = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    t_res                  o_result;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    remote_pairing_filter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // filter state shadow
    logic [ELAPSED_W-1:0] sh_timeout = TIMEOUT_DEFAULT;
    logic [2:0]           sh_static_count = '0;
    logic [KEY_W-1:0]     sh_static [NUM_STATIC_REGS];
    logic [KEY_W-1:0]     paired_keys [PAIRED_SLOTS];
    int                   paired_n = 0;
    logic [KEY_W-1:0]     cand_keys [CAND_SLOTS];
    int                   cand_n = 0;
    logic                 pair_on = 1'b0;
    logic [ELAPSED_W-1:0] elapsed = '0;

    t_res due_results [$];
    bit   row_typed [$];
    t_res row_want [$];

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    int errors = 0;
    int beats_sent = 0;
    int tx_idle = 12;
    int rx_idle = 57;
    int hold_req = 0;
    int n_results = 0;
    int n_fwd = 0;
    int n_learn = 0;
    int n_full = 0;
    int n_timeout = 0;
    int n_cancel = 0;

    function automatic logic key_hit(logic [KEY_W-1:0] stored, logic [KEY_W-1:0] probe);
        if (probe[7:0] == 8'h00) begin
            return stored[KEY_W-1:8] == probe[KEY_W-1:8];
        end
        return stored == probe;
    endfunction

    function automatic t_res filter_predict(t_item beat);
        t_res             r;
        logic [KEY_W-1:0] key;
        logic             known;
        int               seen;
        int               n_static;
        r = '0;
        key = {beat.remote_type, beat.device_id, beat.group_id};
        case (beat.opcode)
            OP_EVENT: begin
                known = 1'b0;
                n_static = (sh_static_count > NUM_STATIC_REGS) ? NUM_STATIC_REGS
                                                               : int'(sh_static_count);
                for (int i = 0; i < n_static; i++) begin
                    if (key_hit(sh_static[i], key)) known = 1'b1;
                end
                for (int i = 0; i < paired_n; i++) begin
                    if (key_hit(paired_keys[i], key)) known = 1'b1;
                end
                if (known) begin
                    r.forward_event = 1'b1;
                end else if (pair_on && beat.is_on_command && key[7:0] != 8'h00) begin
                    seen = 0;
                    for (int i = 0; i < cand_n; i++) begin
                        if (cand_keys[i] == key) seen++;
                    end
                    if (seen >= int'(REQUIRED_PRIOR)) begin
                        if (paired_n < PAIRED_SLOTS) begin
                            paired_keys[paired_n] = key;
                            paired_n++;
                            r.newly_paired = 1'b1;
                        end else begin
                            r.paired_table_full = 1'b1;
                        end
                        pair_on = 1'b0;
                        cand_n = 0;
                    end else begin
                        if (cand_n >= CAND_SLOTS) cand_n = 0;
                        cand_keys[cand_n] = key;
                        cand_n++;
                    end
                end
            end
            OP_TICK: begin
                if (pair_on) begin
                    if (elapsed != ELAPSED_MAX) elapsed = elapsed + 1'b1;
                    if (elapsed > sh_timeout) begin
                        pair_on = 1'b0;
                        cand_n = 0;
                        r.pairing_timed_out = 1'b1;
                    end
                end
            end
            OP_START: begin
                if (!pair_on) begin
                    cand_n = 0;
                    pair_on = 1'b1;
                    r.pairing_started = 1'b1;
                end
                elapsed = '0;
            end
            OP_CANCEL: begin
                if (pair_on) begin
                    pair_on = 1'b0;
                    cand_n = 0;
                    r.pairing_cancelled = 1'b1;
                end
            end
            OP_UNPAIR: begin
                paired_n = 0;
            end
            default: ;
        endcase
        r.pairing_active = pair_on;
        return r;
    endfunction

    task automatic check_field(string name, logic want, logic got);
        if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $error("%s: expected %0b, got %0b", name, want, got);
        end
    endtask

    // score popped beats, then log the beat accepted at this edge
    always @(posedge i_clk) begin : result_check
        t_res want;
        t_res pred;
        bit   typed;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (due_results.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $error("result beat %b with no beat outstanding", o_result);
                end else begin
                    want = due_results.pop_front();
                    check_field("forward_event", want.forward_event, o_result.forward_event);
                    check_field("newly_paired", want.newly_paired, o_result.newly_paired);
                    check_field("paired_table_full", want.paired_table_full,
                                o_result.paired_table_full);
                    check_field("pairing_active", want.pairing_active, o_result.pairing_active);
                    check_field("pairing_started", want.pairing_started,
                                o_result.pairing_started);
                    check_field("pairing_timed_out", want.pairing_timed_out,
                                o_result.pairing_timed_out);
                    check_field("pairing_cancelled", want.pairing_cancelled,
                                o_result.pairing_cancelled);
                    n_results++;
                    n_fwd += want.forward_event;
                    n_learn += want.newly_paired;
                    n_full += want.paired_table_full;
                    n_timeout += want.pairing_timed_out;
                    n_cancel += want.pairing_cancelled;
                end
            end
            if (push && !full) begin
                pred = filter_predict(i_item);
                typed = row_typed.pop_front();
                want = row_want.pop_front();
                due_results.insert(due_results.size(), typed ? want : pred);
            end
        end
    end

    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                stall_left = hold_req;
                hold_req = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= rx_idle);
            end
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("timeout with %0d beats outstanding", due_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_beat(t_item beat, bit typed, t_res want);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < tx_idle) gap++;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        row_typed.insert(row_typed.size(), typed);
        row_want.insert(row_want.size(), want);
        push <= 1'b1;
        i_item <= beat;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic send_model(t_item beat);
        send_beat(beat, 1'b0, '0);
    endtask

    // hold off until every outstanding beat has returned
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic setup(logic [ELAPSED_W-1:0] tmo, logic [2:0] cnt,
                         logic [KEY_W-1:0] s0, logic [KEY_W-1:0] s1,
                         logic [KEY_W-1:0] s2, logic [KEY_W-1:0] s3);
        write_reg(REG_TIMEOUT, {12'h000, tmo});
        write_reg(REG_STATIC_COUNT, {29'h0, cnt});
        write_reg(REG_STATIC_0, s0);
        write_reg(REG_STATIC_1, s1);
        write_reg(REG_STATIC_2, s2);
        write_reg(REG_STATIC_3, s3);
        i_cfg_we <= 1'b0;
        sh_timeout = tmo;
        sh_static_count = cnt;
        sh_static[0] = s0;
        sh_static[1] = s1;
        sh_static[2] = s2;
        sh_static[3] = s3;
        @(posedge i_clk);
    endtask

    function automatic t_item event_beat(logic [KEY_W-1:0] key, logic on);
        t_item b;
        b.opcode = OP_EVENT;
        b.remote_type = key[31:24];
        b.device_id = key[23:8];
        b.group_id = key[7:0];
        b.is_on_command = on;
        return b;
    endfunction

    // command beat with junk in the unused event fields
    function automatic t_item cmd_beat(logic [2:0] op);
        logic [31:0] r;
        t_item       b;
        r = $urandom;
        b = event_beat(r, r[5] ^ r[19]);
        b.opcode = op;
        return b;
    endfunction

    function automatic t_res flags(logic active, logic started, logic cancelled);
        t_res r;
        r = '0;
        r.pairing_active = active;
        r.pairing_started = started;
        r.pairing_cancelled = cancelled;
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        k = $urandom;
        if (k[7:0] == 8'h00) k[0] = 1'b1;
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] pool_variant();
        logic [KEY_W-1:0] k;
        logic [31:0]      r;
        k = key_pool[$urandom_range(POOL_SIZE - 1)];
        r = $urandom_range(9);
        if (r == 7) k[7:0] = 8'h00;
        else if (r == 8) k[7:0] = 8'($urandom_range(255));
        else if (r == 9) k = $urandom;
        return k;
    endfunction

    function automatic t_item noise_beat();
        logic [31:0] v;
        logic [31:0] u;
        v = $urandom_range(99);
        u = $urandom_range(OP_UNUSED_LO, OP_UNUSED_HI);
        if (v < 50) return event_beat(pool_variant(), $urandom_range(99) < 75);
        if (v < 70) return cmd_beat(OP_TICK);
        if (v < 80) return cmd_beat(OP_START);
        if (v < 87) return cmd_beat(OP_CANCEL);
        if (v < 90) return cmd_beat(OP_UNPAIR);
        if (v < 94) return cmd_beat(u[2:0]);
        return event_beat($urandom, 1'($urandom_range(1)));
    endfunction

    initial begin : stimulus
        t_item            dir_item [$];
        bit               dir_typed [$];
        t_res             dir_want [$];
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] k;
        logic [31:0]      r;
        int               phase_end;
        int               n;
        int               sel;

        for (int i = 0; i < POOL_SIZE; i++) begin
            r = $urandom;
            key_pool[i] = {6'h00, r[1:0], 12'h000, r[5:2], 6'h00, r[7:6] | 2'b01};
        end
        for (int i = 0; i < NUM_STATIC_REGS; i++) sh_static[i] = '0;
        key_a = 32'h1234_5601;

        dir_item = '{event_beat(32'hFFFF_FFFF, 1'b1), event_beat(32'h0000_0000, 1'b0),
                     cmd_beat(OP_TICK), cmd_beat(OP_CANCEL), cmd_beat(OP_UNPAIR),
                     cmd_beat(OP_UNUSED_LO), cmd_beat(OP_UNUSED_HI),
                     cmd_beat(OP_START), cmd_beat(OP_START), cmd_beat(OP_TICK),
                     event_beat(key_a, 1'b1), event_beat(key_a, 1'b1),
                     event_beat(key_a, 1'b0), event_beat({key_a[31:8], 8'h00}, 1'b1),
                     event_beat(key_a, 1'b1), event_beat(key_a, 1'b0),
                     event_beat({key_a[31:8], 8'h00}, 1'b0),
                     event_beat({key_a[31:8], 8'h02}, 1'b1),
                     cmd_beat(OP_START), event_beat({key_a[31:8], 8'h02}, 1'b1),
                     event_beat({key_a[31:8], 8'h02}, 1'b1), cmd_beat(OP_UNPAIR),
                     event_beat(key_a, 1'b1), cmd_beat(OP_START), cmd_beat(OP_CANCEL)};
        dir_typed = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0,
                      1, 0, 0, 0, 0, 1, 1};
        for (int i = 0; i < dir_item.size(); i++) dir_want.insert(dir_want.size(), '0);
        dir_want[7] = flags(1'b1, 1'b1, 1'b0);
        dir_want[8] = flags(1'b1, 1'b0, 1'b0);
        dir_want[9] = flags(1'b1, 1'b0, 1'b0);
        dir_want[18] = flags(1'b1, 1'b1, 1'b0);
        dir_want[23] = flags(1'b1, 1'b0, 1'b0);
        dir_want[24] = flags(1'b0, 1'b0, 1'b1);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < dir_item.size(); i++)
            send_beat(dir_item[i], dir_typed[i], dir_want[i]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p)
                0: setup(20'd0, 3'd4, key_pool[0], key_pool[1], key_pool[2], key_pool[3]);
                1: setup(20'hFFFFF, 3'd7, 32'hFFFF_FFFF, key_pool[4], 32'h0000_0000,
                         fresh_key());
                2: setup(20'd3, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF);
                3: setup(20'd8, 3'd2, key_pool[5], {key_pool[6][31:8], 8'hFF}, $urandom,
                         $urandom);
                4: setup(20'($urandom_range(1, 20)), 3'd1, 32'h0000_0000, $urandom,
                         $urandom, $urandom);
                default: setup(TIMEOUT_DEFAULT, 3'd3, key_pool[7], key_pool[8],
                               fresh_key(), 32'h0000_0000);
            endcase
            if (p < 2) begin
                tx_idle = 12;
                rx_idle = 57;
            end else if (p < 4) begin
                tx_idle = 57;
                rx_idle = 12;
            end else begin
                tx_idle = 0;
                rx_idle = 0;
            end
            if (p == 2) hold_req = 150;
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end) begin
                sel = $urandom_range(99);
                if (sel < 45) begin
                    // learn: mostly a start, then three sightings, mostly ON, with noise before each
                    k = ($urandom_range(99) < 70) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                                  : fresh_key();
                    if ($urandom_range(99) < 80) send_model(cmd_beat(OP_START));
                    for (int s = 0; s < 3; s++) begin
                        n = $urandom_range(2);
                        for (int j = 0; j < n; j++) send_model(noise_beat());
                        send_model(event_beat(k, $urandom_range(99) >= 8));
                    end
                end else if (sel < 55) begin
                    // overflow the candidate list
                    send_model(cmd_beat(OP_START));
                    n = $urandom_range(21, 25);
                    for (int j = 0; j < n; j++) send_model(event_beat(fresh_key(), 1'b1));
                end else if (sel < 60) begin
                    send_model(cmd_beat(OP_START));
                    n = (sh_timeout < 12) ? int'(sh_timeout) + 2 : $urandom_range(1, 6);
                    for (int j = 0; j < n; j++) send_model(cmd_beat(OP_TICK));
                end else begin
                    send_model(noise_beat());
                end
            end
        end

        push <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d beats over %0d settings, %0d results checked", beats_sent,
                 NUM_PHASES + 1, n_results);
        $display("forwarded %0d, learned %0d, table full %0d, timeouts %0d, cancels %0d",
                 n_fwd, n_learn, n_full, n_timeout, n_cancel);
        if (errors == 0 && due_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/rpf_pkg.sv
rtl/core/rpf_front.sv
rtl/core/rpf_back.sv
rtl/core/remote_pairing_filter_core.sv
rtl/core/rpf_checker.sv
tb/testbench.sv
